### rtl/alb_pkg.sv
package alb_pkg;

	// sizes of the meter and of the grid
	localparam int HISTORY_LEN = 20;
	localparam int SAMPLE_BITS = 10;
	localparam int GRID_ROWS   = 20;
	localparam int GRID_COLS   = 10;
	localparam int LEVEL_W     = 4;
	localparam int LEVEL_MAX   = 9;
	localparam int LEVEL_GAIN  = 11;
	localparam int PIX_W       = 24;

	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int HIST_W = $clog2(HISTORY_LEN);
	localparam int MOD_W  = ((HIST_W > ROW_W) ? HIST_W : ROW_W) + 1;

	// display modes
	localparam logic MODE_LEVEL    = 1'b0;
	localparam logic MODE_TIMELINE = 1'b1;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [PIX_W-1:0]   pixel_t;

	// window result handed to the renderer
	typedef struct packed {
		logic   start;
		level_t level;
	} lvl_t;

	// colour of each level / column
	function automatic pixel_t palette(input level_t idx);
		pixel_t c;
		case (idx)
			4'd0:    c = 24'h3d01a4;
			4'd1:    c = 24'h0247fe;
			4'd2:    c = 24'h0392ce;
			4'd3:    c = 24'h66b032;
			4'd4:    c = 24'hd0ea2b;
			4'd5:    c = 24'hfefe33;
			4'd6:    c = 24'hfabc02;
			4'd7:    c = 24'hfb9902;
			4'd8:    c = 24'hfd5308;
			4'd9:    c = 24'hfe2712;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

### rtl/audio_level_bar_display.sv
// A window-end beat starts the row sequencer; each row then passes the read stage
// and the result register, one row per cycle for 20 rows while not stalled.
// Input: one sample per cycle while in_ready is high; a window end holds in_ready low
// until the last of the 20 history reads leaves the read stage.
// Output stalls lengthen this. The one RAM read port sets the row rate.
// Reset: min/max reload, write position and mode cleared, history reads as
// zero through per-entry valid bits, so no clearing pass is needed.
module audio_level_bar_display (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [alb_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic                              window_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [alb_pkg::ROW_W-1:0]         row_y,
	output alb_pkg::pixel_t                   pixel_0,
	output alb_pkg::pixel_t                   pixel_1,
	output alb_pkg::pixel_t                   pixel_2,
	output alb_pkg::pixel_t                   pixel_3,
	output alb_pkg::pixel_t                   pixel_4,
	output alb_pkg::pixel_t                   pixel_5,
	output alb_pkg::pixel_t                   pixel_6,
	output alb_pkg::pixel_t                   pixel_7,
	output alb_pkg::pixel_t                   pixel_8,
	output alb_pkg::pixel_t                   pixel_9,
	output logic                              last_row
);
	import alb_pkg::*;

	logic                   mode_q;
	logic                   busy;
	logic                   accept;
	lvl_t                   lvl;
	pixel_t [GRID_COLS-1:0] pixels;

	// mode register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	alb_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample),
		.window_end(window_end),
		.lvl       (lvl)
	);

	alb_render u_render (
		.clk      (clk),
		.arst_n   (arst_n),
		.lvl      (lvl),
		.mode     (mode_q),
		.busy     (busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_y    (row_y),
		.pixels   (pixels),
		.last_row (last_row)
	);

	assign pixel_0 = pixels[0];
	assign pixel_1 = pixels[1];
	assign pixel_2 = pixels[2];
	assign pixel_3 = pixels[3];
	assign pixel_4 = pixels[4];
	assign pixel_5 = pixels[5];
	assign pixel_6 = pixels[6];
	assign pixel_7 = pixels[7];
	assign pixel_8 = pixels[8];
	assign pixel_9 = pixels[9];

endmodule

### rtl/alb_ram.sv
module alb_ram #(
	parameter int DEPTH = 20,
	parameter int WIDTH = 4,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/alb_window.sv
module alb_window (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [alb_pkg::SAMPLE_BITS-1:0]   sample,
	input  logic                              window_end,
	output alb_pkg::lvl_t                     lvl
);
	import alb_pkg::*;

	localparam logic [SAMPLE_BITS:0] FULL = {1'b1, {SAMPLE_BITS{1'b0}}};
	localparam int PW = SAMPLE_BITS + LEVEL_W;

	logic [SAMPLE_BITS:0]   min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS:0]   nmin;
	logic [SAMPLE_BITS-1:0] nmax;
	logic [SAMPLE_BITS-1:0] p2p;
	logic [PW-1:0]          prod;
	level_t                 raw;

	// min and max updated independently with this beat
	assign nmin = ({1'b0, sample} < min_q) ? {1'b0, sample} : min_q;
	assign nmax = (sample > max_q) ? sample : max_q;

	// level = p2p * 11 >> SAMPLE_BITS, clamped; nmin never exceeds nmax here
	assign p2p  = nmax - nmin[SAMPLE_BITS-1:0];
	assign prod = PW'(p2p) * PW'(LEVEL_GAIN);
	assign raw  = prod[PW-1:SAMPLE_BITS];

	always_comb begin
		lvl.start = accept & window_end;
		lvl.level = (raw > level_t'(LEVEL_MAX)) ? level_t'(LEVEL_MAX) : raw;
	end

	// window trackers, reloaded at the end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= FULL;
			max_q <= '0;
		end else if (accept) begin
			if (window_end) begin
				min_q <= FULL;
				max_q <= '0;
			end else begin
				min_q <= nmin;
				max_q <= nmax;
			end
		end
	end

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> nmin <= {1'b0, nmax})
	else $error("window min above max after a sample");

endmodule

### rtl/alb_render.sv
module alb_render (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  alb_pkg::lvl_t                            lvl,
	input  logic                                     mode,
	output logic                                     busy,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [alb_pkg::ROW_W-1:0]                row_y,
	output alb_pkg::pixel_t [alb_pkg::GRID_COLS-1:0] pixels,
	output logic                                     last_row
);
	import alb_pkg::*;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
	localparam logic [HIST_W-1:0] POS_LAST = HIST_W'(HISTORY_LEN - 1);

	// history bookkeeping
	logic [HISTORY_LEN-1:0] vld_q;
	logic [HIST_W-1:0]      wpos_q;
	logic [HIST_W-1:0]      pos_q;
	level_t                 level_q;

	// row sequencer
	logic             active_q;
	logic [ROW_W-1:0] row_q;
	logic             advance;
	logic             issue;

	// read stage
	logic             valid_s1;
	logic [ROW_W-1:0] row_s1;
	logic             hit_s1;
	level_t           rdata;

	// address of the level shown on the current row
	logic [MOD_W-1:0]  age;
	logic [MOD_W-1:0]  sum;
	logic [MOD_W-1:0]  wrapped;
	logic [HIST_W-1:0] k;
	logic              in_hist;

	// result register
	logic                         out_valid_q;
	logic [ROW_W-1:0]             row_y_q;
	logic                         last_q;
	pixel_t [GRID_COLS-1:0]       pix_q;
	level_t                       shown;

	assign advance = !out_valid_q || out_ready;
	assign issue   = active_q && advance;
	assign busy    = active_q || valid_s1;

	always_comb begin
		age     = MOD_W'(ROW_LAST) - MOD_W'(row_q);
		in_hist = age < MOD_W'(HISTORY_LEN);
		sum     = MOD_W'(pos_q) + MOD_W'(HISTORY_LEN) - age;
		wrapped = (sum >= MOD_W'(HISTORY_LEN)) ? sum - MOD_W'(HISTORY_LEN) : sum;
		k       = wrapped[HIST_W-1:0];
	end

	alb_ram #(
		.DEPTH(HISTORY_LEN),
		.WIDTH(LEVEL_W)
	) u_hist (
		.clk  (clk),
		.we   (lvl.start),
		.waddr(wpos_q),
		.wdata(lvl.level),
		.re   (issue),
		.raddr(k),
		.rdata(rdata)
	);

	// store the new level, then walk the rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wpos_q   <= '0;
			pos_q    <= '0;
			level_q  <= '0;
			active_q <= 1'b0;
			row_q    <= '0;
		end else if (lvl.start) begin
			vld_q[wpos_q] <= 1'b1;
			pos_q         <= wpos_q;
			level_q       <= lvl.level;
			wpos_q        <= (wpos_q == POS_LAST) ? '0 : wpos_q + 1'b1;
			active_q      <= 1'b1;
			row_q         <= '0;
		end else if (issue) begin
			row_q <= row_q + 1'b1;
			if (row_q == ROW_LAST) begin
				active_q <= 1'b0;
			end
		end
	end

	// read stage, holds while the result register is full and not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= row_q;
			hit_s1 <= in_hist && vld_q[k];
		end
	end

	// unwritten entries read as zero
	assign shown = hit_s1 ? rdata : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			row_y_q <= row_s1;
			last_q  <= (row_s1 == ROW_LAST);
			for (int j = 0; j < GRID_COLS; j++) begin
				if (mode == MODE_LEVEL) begin
					pix_q[j] <= palette(level_q);
				end else if (shown > level_t'(j)) begin
					pix_q[j] <= palette(level_t'(j));
				end else begin
					pix_q[j] <= '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign row_y     = row_y_q;
	assign last_row  = last_q;
	assign pixels    = pix_q;

	// a new window never lands on a frame still being read
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		lvl.start |-> !active_q && !valid_s1)
	else $error("window end taken while rows still pending");

	a_start_row0: assert property (@(posedge clk) disable iff (!arst_n)
		lvl.start |=> active_q && row_q == '0)
	else $error("frame did not start at row zero");

	a_last_issue: assert property (@(posedge clk) disable iff (!arst_n)
		issue && row_q == ROW_LAST |=> !active_q)
	else $error("sequencer ran past the last row");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(row_s1))
	else $error("read stage lost a row under stall");

endmodule
